// ===== sv/nhbs_pkg.sv =====
package nhbs_pkg;

  // Item kinds carried on the input tuser
  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_WRITE   = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;

  localparam int unsigned TO_W      = 12;
  localparam int unsigned BLK_CNT_W = 10;
  localparam int unsigned HDR_INDEX = 5;
  localparam logic [TO_W-1:0] TO_RESET = 12'hfff;

  // Partner line patterns seen during sync
  localparam logic [2:0] LINES_LOW  = 3'b000;
  localparam logic [2:0] LINES_HIGH = 3'b111;
  localparam logic [3:0] NIB_HIGH   = 4'hf;

  // One result, first field in the highest bits
  typedef struct packed {
    logic       write_accepted;
    logic       error;
    logic       busy_res;
    logic       strobe_out;
    logic [3:0] nibble_out;
  } res_t;

  localparam int unsigned RES_W = $bits(res_t);

endpackage

// ===== sv/nhbs_ctrl.sv =====
module nhbs_ctrl #(
  parameter int unsigned BLOCK_BYTES = 128
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [nhbs_pkg::TO_W-1:0]  cfg_wdata,
  input  logic                       in_accept,
  input  logic [1:0]                 func,
  input  logic [7:0]                 byte_value,
  input  logic [2:0]                 pins_in,
  output logic                       res_valid,
  output nhbs_pkg::res_t             res
);
  import nhbs_pkg::*;

  localparam int unsigned IDX_W = $clog2(BLOCK_BYTES);
  localparam int unsigned WI_W  = $clog2(BLOCK_BYTES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCK_BYTES - 1);
  localparam logic [WI_W-1:0]  FULL_CNT = WI_W'(BLOCK_BYTES);
  localparam logic [WI_W-1:0]  HDR_POS  = WI_W'(HDR_INDEX);

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_SYNC_LO1 = 3'd1,
    PH_SYNC_HI  = 3'd2,
    PH_SYNC_LO2 = 3'd3,
    PH_SEND_LO  = 3'd4,
    PH_SEND_HI  = 3'd5
  } phase_t;

  // Block buffer and its read register
  logic [7:0] mem [BLOCK_BYTES];
  logic [7:0] mem_q;
  logic [7:0] hdr;

  phase_t             phase, phase_next;
  logic [WI_W-1:0]    write_index, write_index_next;
  logic [IDX_W-1:0]   byte_index, byte_index_next;
  logic [TO_W-1:0]    wait_counter, wait_counter_next;
  logic [BLK_CNT_W-1:0] blocks_left, blocks_left_next;
  logic               in_session, in_session_next;
  logic               error_mark, error_mark_next;
  logic               accepted, accepted_next;
  logic [TO_W-1:0]    timeout_limit;

  logic               mem_we;
  logic               poll_fail;
  logic [TO_W-1:0]    wc_inc;
  logic [WI_W-1:0]    wi_inc;
  logic [BLK_CNT_W-1:0] bl_dec;
  logic               ack;

  assign wc_inc = wait_counter + TO_W'(1);
  assign wi_inc = write_index + WI_W'(1);
  assign bl_dec = (blocks_left != '0) ? blocks_left - BLK_CNT_W'(1) : '0;
  assign ack    = pins_in[2];

  // Next state for one item
  always_comb begin
    phase_next        = phase;
    write_index_next  = write_index;
    byte_index_next   = byte_index;
    wait_counter_next = wait_counter;
    blocks_left_next  = blocks_left;
    in_session_next   = in_session;
    error_mark_next   = error_mark;
    accepted_next     = 1'b0;
    mem_we            = 1'b0;
    poll_fail         = 1'b0;
    unique case (func)
      FUNC_TICK: begin
        unique case (phase)
          PH_SYNC_LO1: begin
            if (pins_in == LINES_LOW) begin
              phase_next = PH_SYNC_HI;
              wait_counter_next = '0;
            end else poll_fail = 1'b1;
          end
          PH_SYNC_HI: begin
            if (pins_in == LINES_HIGH) begin
              phase_next = PH_SYNC_LO2;
              wait_counter_next = '0;
            end else poll_fail = 1'b1;
          end
          PH_SYNC_LO2: begin
            if (pins_in == LINES_LOW) begin
              byte_index_next = '0;
              phase_next = PH_SEND_LO;
              wait_counter_next = '0;
            end else poll_fail = 1'b1;
          end
          PH_SEND_LO: begin
            if (ack) begin
              phase_next = PH_SEND_HI;
              wait_counter_next = '0;
            end else poll_fail = 1'b1;
          end
          PH_SEND_HI: begin
            if (!ack) begin
              wait_counter_next = '0;
              if (byte_index == LAST_IDX) begin
                // end of block
                blocks_left_next = bl_dec;
                if (bl_dec == '0) in_session_next = 1'b0;
                phase_next = PH_IDLE;
                byte_index_next = '0;
              end else begin
                byte_index_next = byte_index + IDX_W'(1);
                phase_next = PH_SEND_LO;
              end
            end else poll_fail = 1'b1;
          end
          default: phase_next = PH_IDLE;
        endcase
      end
      FUNC_WRITE: begin
        if (phase == PH_IDLE && write_index < FULL_CNT) begin
          mem_we = 1'b1;
          accepted_next = 1'b1;
          write_index_next = wi_inc;
          if (wi_inc == FULL_CNT) begin
            // buffer full: start the block
            byte_index_next = '0;
            wait_counter_next = '0;
            if (!in_session) begin
              blocks_left_next = {({1'b0, hdr} + 9'd1), 1'b0};
              in_session_next = 1'b1;
              error_mark_next = 1'b0;
              phase_next = PH_SYNC_LO1;
            end else begin
              phase_next = PH_SEND_LO;
            end
          end
        end
      end
      FUNC_RESTART: write_index_next = '0;
      default: ;
    endcase
    // failed poll: count, or abort on timeout
    if (poll_fail) begin
      if (wc_inc >= timeout_limit) begin
        phase_next = PH_IDLE;
        in_session_next = 1'b0;
        error_mark_next = 1'b1;
        wait_counter_next = '0;
      end else begin
        wait_counter_next = wc_inc;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      write_index   <= '0;
      byte_index    <= '0;
      wait_counter  <= '0;
      blocks_left   <= '0;
      in_session    <= 1'b0;
      error_mark    <= 1'b0;
      accepted      <= 1'b0;
      res_valid     <= 1'b0;
      timeout_limit <= TO_RESET;
    end else begin
      res_valid <= in_accept;
      if (cfg_we) timeout_limit <= cfg_wdata;
      if (in_accept) begin
        phase        <= phase_next;
        write_index  <= write_index_next;
        byte_index   <= byte_index_next;
        wait_counter <= wait_counter_next;
        blocks_left  <= blocks_left_next;
        in_session   <= in_session_next;
        error_mark   <= error_mark_next;
        accepted     <= accepted_next;
      end
    end
  end

  // Buffer write, header copy and registered read of the byte being sent
  always_ff @(posedge clk) begin
    if (in_accept && mem_we) begin
      mem[write_index[IDX_W-1:0]] <= byte_value;
      if (write_index == HDR_POS) hdr <= byte_value;
    end
    if (in_accept) mem_q <= mem[byte_index_next];
  end

  // Lines and flags as they stand after the item
  always_comb begin
    res = '0;
    res.busy_res       = (phase != PH_IDLE);
    res.error          = error_mark;
    res.write_accepted = accepted;
    unique case (phase)
      PH_SYNC_HI: begin
        res.nibble_out = NIB_HIGH;
        res.strobe_out = 1'b1;
      end
      PH_SEND_LO: begin
        res.nibble_out = mem_q[3:0];
        res.strobe_out = 1'b1;
      end
      PH_SEND_HI: res.nibble_out = mem_q[7:4];
      default: ;
    endcase
  end

endmodule

// ===== sv/nhbs_outq.sv =====
module nhbs_outq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic [nhbs_pkg::RES_W-1:0]  push_data,
  input  logic                        pop,
  output logic                        not_empty,
  output logic [1:0]                  count,
  output logic [nhbs_pkg::RES_W-1:0]  head
);
  import nhbs_pkg::*;

  // three entries: one in flight plus two waiting
  localparam int unsigned DEPTH = 3;

  logic [RES_W-1:0] q [DEPTH];
  logic [1:0] rd_ptr, wr_ptr;

  function automatic logic [1:0] ptr_inc(input logic [1:0] p);
    ptr_inc = (p == 2'(DEPTH - 1)) ? 2'd0 : p + 2'd1;
  endfunction

  assign not_empty = (count != 2'd0);
  assign head      = q[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop) rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= push_data;
  end

endmodule

// ===== sv/nibble_handshake_block_sender.sv =====
// Channel   | Direction | tdata (low bit up)                    | tuser
// s_axis    | in        | byte_value[7:0] pins_in[10:8]         | func[1:0]
// m_axis    | out       | nibble_out[3:0] strobe_out[4]         | -
//           |           | busy_res[5] error[6] write_accepted[7] |
// cfg       | in        | timeout_limit in cfg_wdata, on cfg_we  | -
//
// One item per cycle while m_axis_tready holds; its result passes through
// the state register (with buffer read), then the output queue.
// The send engine updates in the transfer cycle; the block buffer read of
// the byte on the lines is the registered step before the result.
// rst is synchronous: engine idle, buffer index zero, timeout at 4095.
// Buffer contents are not cleared. A stalled output holds up to three
// results before s_axis_tready drops.
module nibble_handshake_block_sender #(
  parameter int unsigned BLOCK_BYTES = 128
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [15:0]                 s_axis_tdata,   // byte_value, pins_in
  input  logic [1:0]                  s_axis_tuser,   // func
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,   // nibble_out, strobe_out,
                                                      // busy_res, error,
                                                      // write_accepted
  input  logic                        cfg_we,
  input  logic [nhbs_pkg::TO_W-1:0]   cfg_wdata
);
  import nhbs_pkg::*;

  logic       in_accept;
  logic       res_valid;
  res_t       res;
  logic [1:0] q_count;
  logic [2:0] in_flight;

  // Room for everything in flight plus the new transfer
  assign in_flight     = {1'b0, q_count} + {2'b00, res_valid};
  assign s_axis_tready = (in_flight < 3'd3);
  assign in_accept     = s_axis_tvalid & s_axis_tready;

  nhbs_ctrl #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_accept  (in_accept),
    .func       (s_axis_tuser),
    .byte_value (s_axis_tdata[7:0]),
    .pins_in    (s_axis_tdata[10:8]),
    .res_valid  (res_valid),
    .res        (res)
  );

  nhbs_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .pop       (m_axis_tvalid & m_axis_tready),
    .not_empty (m_axis_tvalid),
    .count     (q_count),
    .head      (m_axis_tdata)
  );

endmodule

// ===== sv/nhbs_chk.sv =====
module nhbs_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result shown right after reset");

  // Lines are quiet whenever the engine is idle
  a_idle_lines: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[5]) |-> (m_axis_tdata[4:0] == 5'd0))
    else $error("lines driven while idle");

  // Strobe only during sync or send
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[4]) |-> m_axis_tdata[5])
    else $error("strobe high while idle");

  // An empty output side never holds back the input
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind nibble_handshake_block_sender nhbs_chk u_nhbs_chk (.*);
